/* src/voltmeter_seven_segment_digits_assert.svh */
// Assertion macros shared by the voltmeter digit driver.
`ifndef VOLTMETER_SEVEN_SEGMENT_DIGITS_ASSERT_SVH
`define VOLTMETER_SEVEN_SEGMENT_DIGITS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VSD_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("voltmeter digit driver: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define VSD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("voltmeter digit driver: next-cycle check failed");

`endif

/* src/vsd_pkg.sv */
// Shared constants, types and the segment table of the voltmeter digit driver.
package vsd_pkg;

    // Number of digit positions driven per sample (4 to 8).
    localparam int DIGIT_COUNT = 8;
    // Position whose decimal point is lit (0 to 7); at or past DIGIT_COUNT none is lit.
    localparam int POINT_POSITION = 5;

    // sample*100/51 equals (sample*SCALE_MULT) >> SCALE_SHIFT exactly for 8-bit samples.
    localparam int SCALE_SHIFT = 16;
    localparam logic [16:0] SCALE_MULT = 17'd128502;
    // r/10 equals (r*TEN_RECIP) >> TEN_SHIFT for r below 1029.
    localparam logic [7:0] TEN_RECIP = 8'd205;
    localparam int TEN_SHIFT = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Decimal digits of one scaled sample; all higher positions are zero.
    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } vsd_digits_t;

    // Common-cathode pattern of one decimal digit, segment a in bit 0.
    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

/* src/vsd_front.sv */
// Front end: accepts samples, scales them and splits the result into decimal digits.
module vsd_front
    import vsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  sample,
    output logic        q_push,
    input  logic        q_full,
    output vsd_digits_t q_word
);

    logic        s1_valid_reg;
    logic [8:0]  s1_value_reg;
    logic        s2_valid_reg;
    vsd_digits_t s2_word_reg;

    logic        s1_ready;
    logic        s2_ready;
    logic [24:0] product;
    logic [8:0]  value_next;
    logic [3:0]  hundreds;
    logic [6:0]  rem;
    logic [14:0] tens_product;
    logic [3:0]  tens;
    logic [6:0]  tens_times_ten;
    vsd_digits_t word_next;

    // Stage one: exact scale by 100/51 through a reciprocal multiply.
    assign product    = 25'(sample) * 25'(SCALE_MULT);
    assign value_next = product[SCALE_SHIFT +: 9];

    // Stage two: hundreds by comparison, then tens through a reciprocal of ten.
    always_comb
    begin
        if (s1_value_reg >= 9'd500)
        begin
            hundreds = 4'd5;
            rem      = 7'(s1_value_reg - 9'd500);
        end
        else if (s1_value_reg >= 9'd400)
        begin
            hundreds = 4'd4;
            rem      = 7'(s1_value_reg - 9'd400);
        end
        else if (s1_value_reg >= 9'd300)
        begin
            hundreds = 4'd3;
            rem      = 7'(s1_value_reg - 9'd300);
        end
        else if (s1_value_reg >= 9'd200)
        begin
            hundreds = 4'd2;
            rem      = 7'(s1_value_reg - 9'd200);
        end
        else if (s1_value_reg >= 9'd100)
        begin
            hundreds = 4'd1;
            rem      = 7'(s1_value_reg - 9'd100);
        end
        else
        begin
            hundreds = 4'd0;
            rem      = s1_value_reg[6:0];
        end
    end

    assign tens_product   = 15'(rem) * 15'(TEN_RECIP);
    assign tens           = tens_product[TEN_SHIFT +: 4];
    assign tens_times_ten = 7'({tens, 3'b000}) + 7'({tens, 1'b0});

    assign word_next.hundreds = hundreds;
    assign word_next.tens     = tens;
    assign word_next.ones     = 4'(rem - tens_times_ten);

    assign s2_ready = !s2_valid_reg || !q_full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign full     = !s1_ready;
    assign q_push   = s2_valid_reg;
    assign q_word   = s2_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= push;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_value_reg <= value_next;
        end
        if (s2_ready)
        begin
            s2_word_reg <= word_next;
        end
    end

endmodule

/* src/vsd_queue.sv */
// Short queue of digit words between the front end and the digit sequencer.
module vsd_queue
    import vsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  vsd_digits_t wr_word,
    output logic        q_full,
    input  logic        rd_en,
    output logic        rd_valid,
    output vsd_digits_t rd_word
);

    vsd_digits_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    logic                   do_wr;
    logic                   do_rd;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;

    assign q_full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_word  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    assign wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

/* src/vsd_back.sv */
// Digit sequencer: walks the positions of one word and drives the result register.
module vsd_back
    import vsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  vsd_digits_t head_word,
    output logic        head_take,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  digit_position,
    output logic [7:0]  segments,
    output logic        last
);

    logic [2:0] pos_reg;
    logic       seen_reg;
    logic       out_valid_reg;
    logic [2:0] out_pos_reg;
    logic [7:0] out_seg_reg;
    logic       out_last_reg;

    logic       out_ready;
    logic       fire;
    logic       at_last;
    logic [3:0] digit;
    logic [7:0] seg_next;
    logic       seen_next;

    assign out_ready = !out_valid_reg || pop;
    assign fire      = head_valid && out_ready;
    assign at_last   = (pos_reg == 3'(DIGIT_COUNT - 1));
    assign head_take = fire && at_last;

    // Only the three highest-numbered positions can hold a nonzero digit.
    always_comb
    begin
        if (pos_reg == 3'(DIGIT_COUNT - 1))
        begin
            digit = head_word.ones;
        end
        else if (pos_reg == 3'(DIGIT_COUNT - 2))
        begin
            digit = head_word.tens;
        end
        else if (pos_reg == 3'(DIGIT_COUNT - 3))
        begin
            digit = head_word.hundreds;
        end
        else
        begin
            digit = 4'd0;
        end
    end

    always_comb
    begin
        seg_next  = seg_of_digit(digit);
        seen_next = seen_reg;
        if (pos_reg == 3'(POINT_POSITION) && POINT_POSITION < DIGIT_COUNT)
        begin
            seg_next = seg_next | SEG_POINT;
        end
        if (!seen_reg && digit == 4'd0 && 32'(pos_reg) < POINT_POSITION)
        begin
            seg_next = SEG_BLANK;
        end
        else if (digit != 4'd0)
        begin
            seen_next = 1'b1;
        end
    end

    assign empty          = !out_valid_reg;
    assign digit_position = out_pos_reg;
    assign segments       = out_seg_reg;
    assign last           = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= fire;
            end
            if (fire)
            begin
                pos_reg  <= at_last ? 3'd0 : pos_reg + 3'd1;
                seen_reg <= at_last ? 1'b0 : seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_pos_reg  <= pos_reg;
            out_seg_reg  <= seg_next;
            out_last_reg <= at_last;
        end
    end

endmodule

/* src/voltmeter_seven_segment_digits.sv */
// Top level of the voltmeter seven-segment digit driver.
//
//  Channel   Handshake       Word contents
//  input     push / full     sample (8-bit converter reading)
//  result    pop / empty     digit_position, segments, last
//
// Each sample yields DIGIT_COUNT result words (8 here), one per cycle while pop stays high;
// the digit sequencer, which walks one position per cycle while the result register
// can accept, sets that rate.
// A sample's first word passes through the two front-end stages, the queue and the result register.
// Reset is asynchronous and active low; it empties every stage and the queue.
// The front end keeps accepting into its two stages and the queue while results
// stall, and raises full only when all of them are occupied.
module voltmeter_seven_segment_digits
    import vsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] sample,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] digit_position,
    output logic [7:0] segments,
    output logic       last
);

`include "voltmeter_seven_segment_digits_assert.svh"

    // Front end to queue.
    logic        f_push;
    logic        f_full;
    vsd_digits_t f_word;

    // Queue to digit sequencer.
    logic        h_valid;
    logic        h_take;
    vsd_digits_t h_word;

    // Terms used by the checks at the end of the module.
    logic        at_right_end;
    logic        taken_mid;
    logic [2:0]  pos_step;
    logic        shows_blank;

    // The front end scales the sample to hundredths of a volt and splits it into
    // hundreds, tens and ones over two pipeline stages.
    vsd_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .q_push (f_push),
        .q_full (f_full),
        .q_word (f_word)
    );

    // The queue decouples the front end from the sequencer so that a stalled
    // result side does not block sample acceptance at once.
    vsd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_push),
        .wr_word  (f_word),
        .q_full   (f_full),
        .rd_en    (h_take),
        .rd_valid (h_valid),
        .rd_word  (h_word)
    );

    // The sequencer turns one digit word into DIGIT_COUNT result words, applying
    // leading-zero blanking and the decimal point, and removes the word from the
    // queue when its final position is issued.
    vsd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (h_valid),
        .head_word      (h_word),
        .head_take      (h_take),
        .empty          (empty),
        .pop            (pop),
        .digit_position (digit_position),
        .segments       (segments),
        .last           (last)
    );

    assign at_right_end = (digit_position == 3'(DIGIT_COUNT - 1));
    assign taken_mid    = !empty && pop && !last;
    assign pos_step     = digit_position + 3'd1;
    assign shows_blank  = !empty && (segments == SEG_BLANK);

    // The final word of a sample always sits at the rightmost position.
    `VSD_ASSERT_NOW(a_last_at_end, clk, rst_n, !empty, last == at_right_end)

    // Within a sample, positions advance by one from word to word.
    `VSD_ASSERT_NEXT(a_pos_step, clk, rst_n, taken_mid, empty || digit_position == $past(pos_step))

    // Blanking only ever applies to positions left of the decimal point.
    `VSD_ASSERT_NOW(a_blank_left, clk, rst_n, shows_blank, 32'(digit_position) < POINT_POSITION)

endmodule

/* test/voltmeter_seven_segment_digits_test.sv */
// Self-checking testbench for the voltmeter seven-segment digit driver.
`timescale 1ns / 100ps

module voltmeter_seven_segment_digits_test;
    import vsd_pkg::*;

    // Clock and handshake timing.
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    // The longest receiver hold-off used to back the block up into a full state.
    localparam int HOLD_CYCLES = 150;
    // Settling time allowed after the last predicted word has come out.
    localparam int DRAIN_CYCLES = 20;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_COUNT = 24;

    // One expected digit word as it should appear on the result ports.
    typedef struct packed {
        logic [2:0] position;
        logic [7:0] pattern;
        logic       final_digit;
    } digit_word_t;

    // A directed row carries a sample and, where it is obvious, the eight patterns
    // typed in by hand, position 0 in the top byte.
    typedef struct packed {
        logic [7:0]  sample;
        logic        typed;
        logic [63:0] patterns;
    } readout_row_t;

    // Zero, full scale, one count below full scale, one count and exactly one volt have patterns that
    // can be read straight off the display. A zero below the point is blanked, while
    // the zero at the point itself stays lit. Every other row is predicted.
    localparam readout_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'd0,   1'b1, 64'h00_00_00_00_00_bf_3f_3f},
        '{8'd255, 1'b1, 64'h00_00_00_00_00_ed_3f_3f},
        '{8'd1,   1'b1, 64'h00_00_00_00_00_bf_3f_06},
        '{8'd51,  1'b1, 64'h00_00_00_00_00_86_3f_3f},
        '{8'd254, 1'b1, 64'h00_00_00_00_00_e6_6f_7f},
        '{8'd2,   1'b0, 64'h0},
        '{8'd3,   1'b0, 64'h0},
        '{8'd5,   1'b0, 64'h0},
        '{8'd26,  1'b0, 64'h0},
        '{8'd50,  1'b0, 64'h0},
        '{8'd52,  1'b0, 64'h0},
        '{8'd100, 1'b0, 64'h0},
        '{8'd102, 1'b0, 64'h0},
        '{8'd127, 1'b0, 64'h0},
        '{8'd128, 1'b0, 64'h0},
        '{8'd153, 1'b0, 64'h0},
        '{8'd170, 1'b0, 64'h0},
        '{8'd204, 1'b0, 64'h0},
        '{8'h55,  1'b0, 64'h0},
        '{8'haa,  1'b0, 64'h0},
        '{8'h0f,  1'b0, 64'h0},
        '{8'hf0,  1'b0, 64'h0},
        '{8'h33,  1'b0, 64'h0},
        '{8'hcc,  1'b0, 64'h0}
    };

    // Common-cathode patterns of the decimal digits, segment a in bit 0.
    localparam logic [7:0] DIGIT_PATTERNS [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    localparam logic [7:0] POINT_BIT = 8'h80;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] sample;
    logic       empty;
    logic       pop;
    logic [2:0] digit_position;
    logic [7:0] segments;
    logic       last;

    // Digit words predicted for accepted samples, oldest first.
    digit_word_t pending_digits [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_results = 1'b0;

    voltmeter_seven_segment_digits uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .empty          (empty),
        .pop            (pop),
        .digit_position (digit_position),
        .segments       (segments),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    // Prints one line for a failed check and counts it; the run carries on.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Works out the digit words a sample should produce and queues them. The reading
    // is scaled to hundredths of a volt, split into decimal digits, and leading zeros
    // left of the decimal point are blanked until the first nonzero digit. A typed
    // row replaces the computed patterns with the ones written in the table.
    task automatic predict_readout(input logic [7:0] value, input logic typed,
                                   input logic [63:0] patterns);
        int          scaled;
        int          digit [DIGIT_COUNT];
        bit          seen_nonzero;
        digit_word_t word;
        scaled = int'(value) * 100 / 51;
        seen_nonzero = 1'b0;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--)
        begin
            digit[i] = scaled % 10;
            scaled = scaled / 10;
        end
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            word.position = i[2:0];
            word.pattern = DIGIT_PATTERNS[digit[i]];
            if (i == POINT_POSITION)
                word.pattern = word.pattern | POINT_BIT;
            // The point digit is never blanked; only zeros to its left are.
            if (!seen_nonzero && digit[i] == 0 && i < POINT_POSITION)
                word.pattern = 8'h00;
            else if (digit[i] != 0)
                seen_nonzero = 1'b1;
            if (typed)
                word.pattern = patterns[63 - 8 * i -: 8];
            word.final_digit = (i == DIGIT_COUNT - 1);
            pending_digits.push_back(word);
        end
    endtask

    // Offers one sample, idling first as the current phase asks, and waits until the
    // block takes it. Push is left high on return so back-to-back samples need no gap.
    task automatic send_sample(input logic [7:0] value, input logic typed,
                               input logic [63:0] patterns);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (full);
        predict_readout(value, typed, patterns);
    endtask

    // Mostly uniform readings, with a share of full scale, zero and whole volts,
    // where the digit boundaries sit.
    function automatic logic [7:0] pick_sample();
        logic [7:0] value;
        case ($urandom_range(9))
            0: value = 8'd0;
            1: value = 8'd255;
            2: value = 8'(51 * $urandom_range(5));
            default: value = 8'($urandom_range(255));
        endcase
        return value;
    endfunction

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_sample(pick_sample(), 1'b0, 64'h0);
    endtask

    // Holds the sender back until every predicted word has come out.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: pops at random, or holds off for a long stretch on request so that
    // the block backs up and raises full while samples are still being offered.
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every word taken from the block is compared with the oldest prediction. Outputs
    // are read in the active region of the edge, before any update from that edge.
    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_digits.size() == 0)
                report_mismatch($sformatf("word at position %0d with none predicted",
                                          digit_position));
            else
            begin
                want = pending_digits.pop_front();
                if (digit_position !== want.position)
                    report_mismatch($sformatf("digit_position got %0d, want %0d",
                                              digit_position, want.position));
                if (segments !== want.pattern)
                    report_mismatch($sformatf("segments at %0d got %02h, want %02h",
                                              want.position, segments, want.pattern));
                if (last !== want.final_digit)
                    report_mismatch($sformatf("last at %0d got %0b, want %0b",
                                              want.position, last, want.final_digit));
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        sample <= 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows first, with both sides running flat out.
        for (int r = 0; r < DIRECTED_COUNT; r++)
            send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].typed,
                        DIRECTED_ROWS[r].patterns);

        // Back-pressure: the receiver stops for a long stretch while samples keep
        // coming, so every stage fills and full must hold the sender off.
        hold_results = 1'b1;
        run_phase(12, 0, 0);
        // Then the sender pauses until the block has emptied completely.
        wait_drained();

        run_phase(44, 0, 0);
        run_phase(44, 70, 0);
        run_phase(44, 0, 70);
        run_phase(44, 29, 29);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
